// ===== hw/rtl/wtsc_pkg.sv =====
package wtsc_pkg;

  localparam int unsigned SINE_DEPTH_DEF = 1024;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
  localparam int          CHOP_GAIN_Q16 = 14418;
  localparam logic [31:0] CHOP_PHASE    = 32'd615208747;
  localparam int          SET_DEPTH_Q16 = 11796;
  localparam int          SETMOD_LO     = 53740;
  localparam int          SETMOD_HI     = 77332;
  localparam int          GUARD_COUNTS  = 150;
  localparam longint      PCORR_LIMIT   = 64'sd900 * 64'sd65536;
  localparam longint      OFFSET_LIMIT  = 64'sd4000 * 64'sd65536;
  localparam longint      ERR_LIMIT     = 64'sd1 <<< 46;
  localparam int          PEAK_COS_Q16  = 6554;
  localparam int          PEAK_SIN_Q16  = 64552;
  localparam logic [31:0] SAMPLE_PERIOD = 32'd50;
  localparam logic [31:0] STALL_TIMEOUT = 32'd1400;
  localparam int          STALL_DTG     = 250;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_LIMIT = 2'd1;
  localparam logic [1:0] FAULT_STALL = 2'd2;

  typedef enum logic [2:0] {
    CFG_CENTER    = 3'd0,
    CFG_SPC       = 3'd1,
    CFG_AMPLITUDE = 3'd2,
    CFG_WAVE_STEP = 3'd3,
    CFG_SET_STEP  = 3'd4,
    CFG_TRACK     = 3'd5,
    CFG_RECENTER  = 3'd6,
    CFG_SOFT_LIM  = 3'd7
  } cfg_idx_e;

  // Datapath micro-ops, issued in this order
  typedef enum logic [4:0] {
    OP_NONE, OP_REL, OP_PH, OP_LOOK, OP_SETM, OP_SETMOD, OP_MIX, OP_AMP,
    OP_WAVE, OP_DIFF, OP_ERRM, OP_ERR, OP_TRK_LO, OP_TRK_HI, OP_TRK_ACC,
    OP_PCORR, OP_REC_ACC, OP_DRIFT, OP_TARGET, OP_STALL
  } op_e;

  typedef struct packed {
    logic capture;
    logic load_out;
    op_e  op;
  } dp_cmd_t;

  typedef struct packed {
    logic faulted;
    logic limit_hit;
  } dp_stat_t;

  // Rounding right shift, half away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -signed'(m) : signed'(m);
  endfunction

  function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // First-quadrant sine in Q16 of r/2^30 quarter turns (Taylor series in Q30)
  function automatic logic [16:0] quarter_sine(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    sum = clamp64(sum, 64'sd0, 64'sd1 <<< 30);
    sum = (sum + 64'sd8192) >>> 14;
    return sum[16:0];
  endfunction

endpackage

// ===== hw/rtl/wtsc_ctrl.sv =====
module wtsc_ctrl
  import wtsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_axis_tvalid,
  output logic     s_axis_tready,
  output logic     m_axis_tvalid,
  input  logic     m_axis_tready,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_e;

  state_e state_q;
  op_e    op_q;
  logic   out_valid_q;
  logic   load_out;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign load_out      = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);

  assign cmd_o.capture  = s_axis_tvalid && (state_q == ST_IDLE);
  assign cmd_o.load_out = load_out;
  assign cmd_o.op       = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (stat_i.faulted) begin
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_RUN;
              op_q    <= OP_REL;
            end
          end
        end
        ST_RUN: begin
          if ((op_q == OP_PH && stat_i.limit_hit) || op_q == OP_STALL) begin
            state_q <= ST_FINISH;
            op_q    <= OP_NONE;
          end else begin
            op_q <= op_e'(op_q + 5'd1);
          end
        end
        ST_FINISH: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          op_q    <= OP_NONE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/wtsc_datapath.sv =====
module wtsc_datapath
  import wtsc_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic signed [31:0]     target_steps_o,
  output logic [1:0]             fault_o
);

  localparam int unsigned AW  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned QD  = SINE_TABLE_DEPTH / 4;
  localparam int unsigned MW  = AW - 1;
  localparam int unsigned RSH = 32 - AW;

  // quarter-wave table, entries 0..QD inclusive
  logic [16:0] qtab [QD+1];
  for (genvar g = 0; g <= QD; g++) begin : g_qtab
    assign qtab[g] = quarter_sine(64'(g) << RSH);
  end

  function automatic logic [MW:0] sine_sel(input logic [31:0] ph);
    logic [AW-1:0] idx;
    logic [MW-1:0] j;
    logic [MW-1:0] m;
    idx = ph[31 -: AW];
    j   = {1'b0, idx[AW-3:0]};
    m   = idx[AW-2] ? MW'(QD) - j : j;
    return {idx[AW-1], m};
  endfunction

  // config
  logic signed [31:0] center_q, spc_q;
  logic [11:0]        amp_q;
  logic [31:0]        wps_q, sps_q;
  logic [15:0]        track_q, rec_q, soft_q;

  // model state
  logic signed [31:0] drift_q, held_q;
  logic               top_q, bot_q;
  logic [31:0]        last_sample_q, last_move_q;
  logic signed [31:0] last_count_q;
  logic [1:0]         fault_q;

  // work registers
  logic [31:0]        now_q, ph_q;
  logic signed [31:0] enc_q, dtg_q;
  logic signed [32:0] rel_q, diff_q;
  logic signed [17:0] s1_q, c1_q, sc_q, ss_q, setmod_q, mix_q, wave_q;
  logic signed [47:0] err_q;
  logic signed [36:0] pcorr_q;
  logic signed [63:0] p_q, acc_q;
  logic signed [31:0] out_target_q;
  logic [1:0]         out_fault_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic [MW:0]        sel [4];
  logic signed [17:0] sval [4];
  logic [31:0]        sph [4];

  logic signed [33:0] rel_w, soft_w;
  logic [15:0]        lim;
  logic signed [63:0] lim_w, gain, off, sum, tgt;
  logic               near_peak, near_top, near_bot;
  logic               elapsed, moved, big_dtg;
  logic [31:0]        lm_new;

  assign target_steps_o   = out_target_q;
  assign fault_o          = out_fault_q;
  assign stat_o.faulted   = (fault_q != FAULT_NONE);
  assign rel_w            = 34'(rel_q);
  assign soft_w           = signed'({18'd0, soft_q});
  assign stat_o.limit_hit = (rel_w > soft_w) || (rel_w < -soft_w);

  assign sph[0] = ph_q;
  assign sph[1] = ph_q + 32'h4000_0000;
  assign sph[2] = (ph_q << 1) + ph_q + CHOP_PHASE;
  assign sph[3] = p_q[31:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sel[i]  = sine_sel(sph[i]);
      sval[i] = sel[i][MW] ? -signed'({1'b0, qtab[sel[i][MW-1:0]]})
                           : signed'({1'b0, qtab[sel[i][MW-1:0]]});
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_REL: begin
        mul_a = {1'b0, now_q};
        mul_b = {1'b0, wps_q};
      end
      OP_PH: begin
        mul_a = {1'b0, now_q};
        mul_b = {1'b0, sps_q};
      end
      OP_SETM: begin
        mul_a = 33'(SET_DEPTH_Q16);
        mul_b = 33'(ss_q);
      end
      OP_SETMOD: begin
        mul_a = 33'(CHOP_GAIN_Q16);
        mul_b = 33'(sc_q);
      end
      OP_MIX: begin
        mul_a = {21'd0, amp_q};
        mul_b = 33'(setmod_q);
      end
      OP_AMP: begin
        mul_a = p_q[32:0];
        mul_b = 33'(mix_q);
      end
      OP_ERRM: begin
        mul_a = diff_q;
        mul_b = 33'(spc_q);
      end
      OP_TRK_LO: begin
        mul_a = {17'd0, track_q};
        mul_b = {9'd0, err_q[23:0]};
      end
      OP_TRK_HI: begin
        mul_a = {17'd0, track_q};
        mul_b = 33'(signed'(err_q[47:24]));
      end
      OP_TRK_ACC: begin
        mul_a = {17'd0, rec_q};
        mul_b = {9'd0, err_q[23:0]};
      end
      OP_PCORR: begin
        mul_a = {17'd0, rec_q};
        mul_b = 33'(signed'(err_q[47:24]));
      end
      OP_REC_ACC, OP_DRIFT: begin
        mul_a = 33'(wave_q);
        mul_b = 33'(spc_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    lim       = (soft_q > 16'(GUARD_COUNTS)) ? soft_q - 16'(GUARD_COUNTS) : 16'd0;
    lim_w     = 64'(lim);
    near_peak = (c1_q < 18'sd6554) && (c1_q > -18'sd6554);
    near_top  = near_peak && (s1_q > 18'(PEAK_SIN_Q16));
    near_bot  = near_peak && (s1_q < -18'(PEAK_SIN_Q16));
    gain      = rnd_shift(acc_q, 16);
    off       = 64'(drift_q);
    if (near_top && !top_q) off = off + gain;
    if (near_bot && !bot_q) off = off + gain;
    off       = clamp64(off, -OFFSET_LIMIT, OFFSET_LIMIT);
    sum       = p_q + 64'(drift_q) + 64'(pcorr_q);
    tgt       = clamp64(rnd_shift(sum, 16), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 64'sd1);
    elapsed   = (now_q - last_sample_q) >= SAMPLE_PERIOD;
    moved     = (enc_q != last_count_q);
    lm_new    = moved ? now_q : last_move_q;
    big_dtg   = (dtg_q > 32'(STALL_DTG)) || (dtg_q < -32'(STALL_DTG));
  end

  // datapath work registers
  always_ff @(posedge clk_i) begin
    p_q <= prod[63:0];
    if (cmd_i.capture) begin
      now_q <= in_data_i[31:0];
      enc_q <= signed'(in_data_i[63:32]);
      dtg_q <= signed'(in_data_i[95:64]);
    end
    if (cmd_i.load_out) begin
      out_target_q <= held_q;
      out_fault_q  <= fault_q;
    end
    case (cmd_i.op)
      OP_REL:    rel_q <= 33'(enc_q) - 33'(center_q);
      OP_PH:     ph_q  <= p_q[31:0] + 32'h4000_0000;
      OP_LOOK: begin
        s1_q <= sval[0];
        c1_q <= sval[1];
        sc_q <= sval[2];
        ss_q <= sval[3];
      end
      OP_SETMOD: setmod_q <= 18'(clamp64(64'sd65536 + rnd_shift(p_q, 16),
                                         64'(SETMOD_LO), 64'(SETMOD_HI)));
      OP_MIX:    mix_q  <= 18'(64'(s1_q) + rnd_shift(p_q, 16));
      OP_WAVE:   wave_q <= 18'(clamp64(rnd_shift(p_q, 32), -lim_w, lim_w));
      OP_DIFF:   diff_q <= 33'(wave_q) - rel_q;
      OP_ERR:    err_q  <= 48'(clamp64(p_q, -ERR_LIMIT, ERR_LIMIT));
      OP_TRK_HI: acc_q  <= p_q;
      OP_TRK_ACC: acc_q <= acc_q + (p_q <<< 24);
      OP_PCORR: begin
        pcorr_q <= 37'(clamp64(rnd_shift(acc_q, 16), -PCORR_LIMIT, PCORR_LIMIT));
        acc_q   <= p_q;
      end
      OP_REC_ACC: acc_q <= acc_q + (p_q <<< 24);
      default: ;
    endcase
  end

  // config and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q      <= '0;
      spc_q         <= 32'sd65536;
      amp_q         <= 12'd950;
      wps_q         <= 32'd773094;
      sps_q         <= 32'd64425;
      track_q       <= 16'd22938;
      rec_q         <= 16'd1311;
      soft_q        <= 16'd2600;
      drift_q       <= '0;
      held_q        <= '0;
      top_q         <= 1'b0;
      bot_q         <= 1'b0;
      last_sample_q <= '0;
      last_move_q   <= '0;
      last_count_q  <= '0;
      fault_q       <= FAULT_NONE;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CENTER:    center_q <= signed'(cfg_data_i);
          CFG_SPC:       spc_q    <= signed'(cfg_data_i);
          CFG_AMPLITUDE: amp_q    <= cfg_data_i[11:0];
          CFG_WAVE_STEP: wps_q    <= cfg_data_i;
          CFG_SET_STEP:  sps_q    <= cfg_data_i;
          CFG_TRACK:     track_q  <= cfg_data_i[15:0];
          CFG_RECENTER:  rec_q    <= cfg_data_i[15:0];
          CFG_SOFT_LIM:  soft_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_PH: begin
          if (stat_o.limit_hit) fault_q <= FAULT_LIMIT;
        end
        OP_DRIFT: begin
          top_q   <= near_top;
          bot_q   <= near_bot;
          drift_q <= 32'(off);
        end
        OP_TARGET: held_q <= 32'(tgt);
        OP_STALL: begin
          if (elapsed) begin
            last_sample_q <= now_q;
            last_move_q   <= lm_new;
            last_count_q  <= enc_q;
            if (big_dtg && ((now_q - lm_new) > STALL_TIMEOUT)) fault_q <= FAULT_STALL;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/wave_tracking_stepper_controller_top.sv =====
// An input beat steps through the micro-op sequence to an output beat (the ops
// are skipped when a fault is latched and end after OP_PH on a soft-limit hit),
// plus any wait on the output side. One item is in work at a time; the shared
// 33x33 multiplier takes the chained products one per cycle from the sequencer.
// A finished result sits in an output register while the next item is taken.
// Reset (rst_ni low, async): config to defaults, drift, latches, stall timers,
// held target and fault cleared.
module wave_tracking_stepper_controller_top
  import wtsc_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // time_ms, enc_count, steps_to_go
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // target_steps, fault, zero pad
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic signed [31:0] target_steps;
  logic [1:0]         fault;

  wtsc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  wtsc_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_data_i      (s_axis_tdata),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .target_steps_o (target_steps),
    .fault_o        (fault)
  );

  assign m_axis_tdata = {6'd0, fault, target_steps};

endmodule

// ===== hw/rtl/wtsc_checker.sv =====
module wtsc_checker
  import wtsc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  // one item in flight: busy right after an accepted beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_fault_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'b11 && m_axis_tdata[39:34] == 6'd0)
    else $error("bad fault code or pad bits");

  // a latched fault never clears on the next delivered beat
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[33:32] != FAULT_NONE
    |=> !m_axis_tvalid || m_axis_tdata[33:32] == $past(m_axis_tdata[33:32]))
    else $error("latched fault cleared");

endmodule

bind wave_tracking_stepper_controller_top wtsc_checker u_wtsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
